// ----- design/one_button_clock_setter_core_defines.svh -----
// Assertion macros for the checker file of the clock setter.
`ifndef ONE_BUTTON_CLOCK_SETTER_CORE_DEFINES_SVH
`define ONE_BUTTON_CLOCK_SETTER_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define OBCS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define OBCS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/obcs_pkg.sv -----
// Types and constants shared by the one-button clock setter.
package obcs_pkg;

	localparam int unsigned CNT_W = 14;
	localparam logic [CNT_W-1:0] CNT_MAX = 14'h3fff;

	localparam logic [5:0] HOUR_WRAP   = 6'd24;
	localparam logic [6:0] MINUTE_WRAP = 7'd60;

	localparam logic [CNT_W-1:0] LONG_PRESS_RESET   = 14'd1000;
	localparam logic [CNT_W-1:0] IDLE_TIMEOUT_RESET = 14'd10000;

	localparam logic [1:0] MASK_ALL = 2'b11;
	localparam logic [1:0] MASK_HOUR = 2'b01;
	localparam logic [1:0] MASK_MINUTE = 2'b10;

	localparam logic FIELD_HOUR   = 1'b0;
	localparam logic FIELD_MINUTE = 1'b1;

	localparam logic CFG_LONG_PRESS   = 1'b0;
	localparam logic CFG_IDLE_TIMEOUT = 1'b1;

	localparam logic ACT_ENTER = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	typedef struct packed {
		logic [4:0]       hour;
		logic [5:0]       minute;
		logic             press_active;
		logic [CNT_W-1:0] press_count;
		logic [CNT_W-1:0] idle_count;
		logic [1:0]       blink_mask;
		logic             field_select;
		logic [1:0]       shown_mask;
	} edit_t;

	typedef struct packed {
		edit_t st;
		logic  refreshed;
		logic  commit;
	} pass_res_t;

endpackage

// ----- design/obcs_set_pass.sv -----
// One pass of the setting routine: button handling, blink refresh and idle timeout.
module obcs_set_pass #(
	parameter int unsigned BLINK_PERIOD_LOG2 = 8
) (
	input  obcs_pkg::edit_t          cur,
	input  logic                     button_down,
	input  logic [obcs_pkg::CNT_W-1:0] long_press_ticks,
	input  logic [obcs_pkg::CNT_W-1:0] idle_timeout_ticks,
	output obcs_pkg::pass_res_t      res
);

	obcs_pkg::edit_t st;
	logic [5:0] hour_inc;
	logic [6:0] minute_inc;
	logic [obcs_pkg::CNT_W-1:0] idle_next;

	always_comb begin
		st = cur;
		hour_inc = {1'b0, cur.hour} + 6'd1;
		minute_inc = {1'b0, cur.minute} + 7'd1;

		// A release ends the press: long ones swap the field, short ones step it.
		if (!button_down && cur.press_active) begin
			if (cur.press_count > long_press_ticks) begin
				st.field_select = ~cur.field_select;
				st.blink_mask = obcs_pkg::MASK_ALL;
			end else begin
				if (cur.field_select == obcs_pkg::FIELD_HOUR) begin
					st.hour = (hour_inc >= obcs_pkg::HOUR_WRAP) ? 5'd0 : hour_inc[4:0];
				end else begin
					st.minute = (minute_inc >= obcs_pkg::MINUTE_WRAP) ?
						6'd0 : minute_inc[5:0];
				end
				st.idle_count = '0;
			end
			st.press_active = 1'b0;
		end
		if (button_down && !cur.press_active) begin
			st.press_active = 1'b1;
			st.press_count = '0;
		end

		res.refreshed = 1'b0;
		if (st.idle_count[BLINK_PERIOD_LOG2-1:0] == '0) begin
			st.shown_mask = st.blink_mask;
			res.refreshed = 1'b1;
			st.blink_mask = st.blink_mask ^ ((st.field_select == obcs_pkg::FIELD_HOUR) ?
				obcs_pkg::MASK_HOUR : obcs_pkg::MASK_MINUTE);
		end
		if (st.press_active && st.press_count != obcs_pkg::CNT_MAX) begin
			st.press_count = st.press_count + 1'b1;
		end
		// The counter wraps within its own width.
		idle_next = st.idle_count + 1'b1;
		st.idle_count = idle_next;
		res.commit = idle_next >= idle_timeout_ticks;
		res.st = st;
	end

endmodule

// ----- design/one_button_clock_setter_core.sv -----
// Top level of the one-button clock setter.
// Takes one word per clock cycle: an enter word loads the time, a tick word (one per
// millisecond) advances the setting routine. Each accepted word gives exactly one result
// word, held in a single output register in the cycle after acceptance; in_ready is high
// whenever that register is empty or being read, so words flow back to back at one per
// cycle. Configuration writes take effect at once and are meant for idle periods.
module one_button_clock_setter_core #(
	parameter int unsigned BLINK_PERIOD_LOG2 = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [13:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic        button_down,
	input  logic [4:0]  load_hour,
	input  logic [5:0]  load_minute,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  hour_value,
	output logic [5:0]  minute_value,
	output logic [1:0]  display_mask,
	output logic        refresh,
	output logic        editing,
	output logic        commit
);

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_WAIT   = 2'd1,
		PH_SET    = 2'd2,
		PH_UNUSED = 2'd3
	} phase_t;

	phase_t phase_q, phase_nxt;
	obcs_pkg::edit_t st_q, st_nxt, pre;
	obcs_pkg::pass_res_t pass_res;
	logic [obcs_pkg::CNT_W-1:0] long_press_q, idle_timeout_q;

	logic        out_valid_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [1:0]  mask_q;
	logic        refresh_q, editing_q, commit_q;

	logic accept, is_tick, release_tick, run_pass;

	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;
	assign is_tick = (action == obcs_pkg::ACT_TICK);
	assign release_tick = is_tick && (phase_q == PH_WAIT) && !button_down;
	assign run_pass = is_tick && ((phase_q == PH_SET) || release_tick);

	// The first tick with the button up starts setting mode from a clean slate.
	always_comb begin
		pre = st_q;
		if (release_tick) begin
			pre.blink_mask = obcs_pkg::MASK_ALL;
			pre.field_select = obcs_pkg::FIELD_HOUR;
			pre.press_active = 1'b0;
			pre.idle_count = '0;
			pre.shown_mask = obcs_pkg::MASK_ALL;
		end
	end

	obcs_set_pass #(
		.BLINK_PERIOD_LOG2(BLINK_PERIOD_LOG2)
	) u_pass (
		.cur(pre),
		.button_down(button_down),
		.long_press_ticks(long_press_q),
		.idle_timeout_ticks(idle_timeout_q),
		.res(pass_res)
	);

	always_comb begin
		st_nxt = st_q;
		phase_nxt = phase_q;
		if (!is_tick) begin
			st_nxt.hour = load_hour;
			st_nxt.minute = load_minute;
			phase_nxt = PH_WAIT;
		end else if (run_pass) begin
			st_nxt = pass_res.st;
			phase_nxt = pass_res.commit ? PH_IDLE : PH_SET;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			st_q <= '{
				hour: 5'd0, minute: 6'd0, press_active: 1'b0,
				press_count: '0, idle_count: '0,
				blink_mask: obcs_pkg::MASK_ALL, field_select: obcs_pkg::FIELD_HOUR,
				shown_mask: obcs_pkg::MASK_ALL
			};
			long_press_q <= obcs_pkg::LONG_PRESS_RESET;
			idle_timeout_q <= obcs_pkg::IDLE_TIMEOUT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					obcs_pkg::CFG_LONG_PRESS:   long_press_q <= cfg_data;
					obcs_pkg::CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				phase_q <= phase_nxt;
				st_q <= st_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result word payload; only the valid flag needs a reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			hour_q <= st_nxt.hour;
			minute_q <= st_nxt.minute;
			mask_q <= st_nxt.shown_mask;
			refresh_q <= run_pass && pass_res.refreshed;
			editing_q <= (phase_nxt == PH_WAIT) || (phase_nxt == PH_SET);
			commit_q <= run_pass && pass_res.commit;
		end
	end

	assign out_valid = out_valid_q;
	assign hour_value = hour_q;
	assign minute_value = minute_q;
	assign display_mask = mask_q;
	assign refresh = refresh_q;
	assign editing = editing_q;
	assign commit = commit_q;

endmodule

// ----- design/obcs_checker.sv -----
// Port-level checks for the one-button clock setter, bound to its top level.
`include "one_button_clock_setter_core_defines.svh"

module obcs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       action,
	input logic       out_valid,
	input logic       out_ready,
	input logic [4:0] hour_value,
	input logic [5:0] minute_value,
	input logic [1:0] display_mask,
	input logic       refresh,
	input logic       editing,
	input logic       commit
);

	logic [15:0] out_word;
	logic        in_acc;

	assign out_word = {hour_value, minute_value, display_mask, refresh, editing, commit};
	assign in_acc = in_valid && in_ready;

	// A stalled result word must hold still.
	`OBCS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_word), "stalled word changed")

	// An empty output register never blocks the input.
	`OBCS_ASSERT_ALWAYS(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

	// An enter word always leaves the block editing, without a commit.
	`OBCS_ASSERT(a_enter_edits, in_acc && !action |=> out_valid && editing && !commit, "enter word not editing")

	// Committing ends the edit session.
	`OBCS_ASSERT(a_commit_ends, out_valid && commit |-> !editing, "commit while still editing")

	// A refresh without commit only happens while setting.
	`OBCS_ASSERT(a_refresh_editing, out_valid && refresh && !commit |-> editing, "refresh outside set mode")

endmodule

bind one_button_clock_setter_core obcs_checker u_obcs_checker (.*);

// ----- tb/sv/tb_one_button_clock_setter_core.sv -----
// Self-checking testbench for the one-button clock setter core.
module tb_one_button_clock_setter_core;

	localparam int unsigned BLINK_LOG2 = 8;
	localparam int unsigned TOTAL_WORDS = 1100;
	localparam int unsigned DRAIN_LIMIT = 5000;

	typedef enum logic [1:0] {
		SET_IDLE = 2'd0,
		SET_WAIT = 2'd1,
		SET_EDIT = 2'd2
	} setter_phase_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [1:0] mask;
		logic       refresh;
		logic       editing;
		logic       commit;
	} readout_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = obcs_pkg::CFG_LONG_PRESS;
	logic [13:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = obcs_pkg::ACT_TICK;
	logic        button_down = 1'b0;
	logic [4:0]  load_hour = '0;
	logic [5:0]  load_minute = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  hour_value;
	logic [5:0]  minute_value;
	logic [1:0]  display_mask;
	logic        refresh;
	logic        editing;
	logic        commit;

	// Own copy of the setter state and its registers.
	setter_phase_t              m_phase = SET_IDLE;
	logic [4:0]                 m_hour = '0;
	logic [5:0]                 m_minute = '0;
	logic                       m_pressing = 1'b0;
	logic [obcs_pkg::CNT_W-1:0] m_press_cnt = '0;
	logic [obcs_pkg::CNT_W-1:0] m_idle_cnt = '0;
	logic [1:0]                 m_blink = obcs_pkg::MASK_ALL;
	logic                       m_field = obcs_pkg::FIELD_HOUR;
	logic [1:0]                 m_shown = obcs_pkg::MASK_ALL;
	logic                       m_refreshed = 1'b0;
	logic [obcs_pkg::CNT_W-1:0] m_long_press = obcs_pkg::LONG_PRESS_RESET;
	logic [obcs_pkg::CNT_W-1:0] m_timeout = obcs_pkg::IDLE_TIMEOUT_RESET;

	readout_t    expected_readouts[$];
	int unsigned n_mismatch = 0;
	int unsigned n_words = 0;
	int unsigned n_worked = 0;
	int unsigned n_results = 0;
	int unsigned n_commits = 0;
	int unsigned n_refreshes = 0;

	logic src_steady = 1'b0;
	logic sink_steady = 1'b0;
	logic sink_stall = 1'b0;

	one_button_clock_setter_core #(
		.BLINK_PERIOD_LOG2(BLINK_LOG2)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.button_down (button_down),
		.load_hour   (load_hour),
		.load_minute (load_minute),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hour_value  (hour_value),
		.minute_value(minute_value),
		.display_mask(display_mask),
		.refresh     (refresh),
		.editing     (editing),
		.commit      (commit)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

	// One pass of the set routine; returns 1 when the idle timeout has run out.
	function automatic logic edit_pass(input logic down);
		if (!down && m_pressing) begin
			if (m_press_cnt > m_long_press) begin
				m_field = ~m_field;
				m_blink = obcs_pkg::MASK_ALL;
			end else begin
				if (m_field == obcs_pkg::FIELD_HOUR)
					m_hour = ({1'b0, m_hour} + 6'd1 >= obcs_pkg::HOUR_WRAP) ?
						5'd0 : m_hour + 5'd1;
				else
					m_minute = ({1'b0, m_minute} + 7'd1 >= obcs_pkg::MINUTE_WRAP) ?
						6'd0 : m_minute + 6'd1;
				m_idle_cnt = '0;
			end
			m_pressing = 1'b0;
		end
		if (down && !m_pressing) begin
			m_pressing = 1'b1;
			m_press_cnt = '0;
		end
		if (m_idle_cnt[BLINK_LOG2-1:0] == '0) begin
			m_shown = m_blink;
			m_refreshed = 1'b1;
			m_blink = m_blink ^ ((m_field == obcs_pkg::FIELD_HOUR) ?
				obcs_pkg::MASK_HOUR : obcs_pkg::MASK_MINUTE);
		end
		if (m_pressing && m_press_cnt != obcs_pkg::CNT_MAX)
			m_press_cnt = m_press_cnt + 1'b1;
		m_idle_cnt = m_idle_cnt + 1'b1;
		return m_idle_cnt >= m_timeout;
	endfunction

	function automatic readout_t predict_readout(input logic act, input logic down,
			input logic [4:0] new_hour, input logic [5:0] new_minute);
		readout_t r;
		logic     committed;
		committed = 1'b0;
		m_refreshed = 1'b0;
		n_words++;
		if (!(act == obcs_pkg::ACT_TICK && m_phase == SET_IDLE))
			n_worked++;
		if (act == obcs_pkg::ACT_ENTER) begin
			m_hour = new_hour;
			m_minute = new_minute;
			m_phase = SET_WAIT;
		end else if (m_phase == SET_WAIT) begin
			// The release tick clears the edit state and runs the first pass at once.
			if (!down) begin
				m_blink = obcs_pkg::MASK_ALL;
				m_field = obcs_pkg::FIELD_HOUR;
				m_pressing = 1'b0;
				m_idle_cnt = '0;
				m_shown = obcs_pkg::MASK_ALL;
				m_refreshed = 1'b1;
				m_phase = SET_EDIT;
				committed = edit_pass(down);
			end
		end else if (m_phase == SET_EDIT) begin
			committed = edit_pass(down);
		end
		if (committed)
			m_phase = SET_IDLE;
		r.hour = m_hour;
		r.minute = m_minute;
		r.mask = m_shown;
		r.refresh = m_refreshed;
		r.editing = (m_phase == SET_WAIT || m_phase == SET_EDIT);
		r.commit = committed;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		n_mismatch++;
		if (n_mismatch <= 30)
			$display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch(name, got, want);
	endtask

	// Predict at acceptance first, so that the queue is never behind the output.
	always @(posedge clk) begin
		readout_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_readouts.push_back(predict_readout(action, button_down,
					load_hour, load_minute));
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_readouts.size() == 0) begin
					report_mismatch("result word with none expected", 1, 0);
				end else begin
					want = expected_readouts.pop_front();
					check_field("hour_value", hour_value, want.hour);
					check_field("minute_value", minute_value, want.minute);
					check_field("display_mask", display_mask, want.mask);
					check_field("refresh", refresh, want.refresh);
					check_field("editing", editing, want.editing);
					check_field("commit", commit, want.commit);
					n_commits += want.commit;
					n_refreshes += want.refresh;
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (sink_stall)
				out_ready <= 1'b0;
			else if (sink_steady)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(99) >= 33);
		end
	end

	task automatic send_word(input logic act, input logic down, input logic [4:0] hour,
			input logic [5:0] minute);
		while (!src_steady && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		button_down <= down;
		load_hour <= hour;
		load_minute <= minute;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic send_ticks(input logic down, input int unsigned count);
		for (int unsigned i = 0; i < count; i++)
			send_word(obcs_pkg::ACT_TICK, down, 5'($urandom), 6'($urandom));
	endtask

	task automatic press(input int unsigned held, input int unsigned released);
		send_ticks(1'b1, held);
		send_ticks(1'b0, released);
	endtask

	// Stops offering words and waits for every outstanding result, with a limit.
	task automatic wait_for_results();
		int unsigned waited;
		in_valid <= 1'b0;
		waited = 0;
		// Let the last accepted word reach the predictor before looking at the queue.
		@(posedge clk);
		while (expected_readouts.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input logic [obcs_pkg::CNT_W-1:0] long_press,
			input logic [obcs_pkg::CNT_W-1:0] timeout);
		cfg_we <= 1'b1;
		cfg_index <= obcs_pkg::CFG_LONG_PRESS;
		cfg_data <= long_press;
		@(posedge clk);
		m_long_press = long_press;
		cfg_index <= obcs_pkg::CFG_IDLE_TIMEOUT;
		cfg_data <= timeout;
		@(posedge clk);
		m_timeout = timeout;
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed_editing();
		// Reset settings: ticks while idle change nothing, then a short press wraps the hour.
		send_ticks(1'b0, 1);
		send_ticks(1'b1, 1);
		send_word(obcs_pkg::ACT_ENTER, 1'b1, 5'd23, 6'd59);
		send_ticks(1'b1, 2);
		send_ticks(1'b0, 1);
		press(2, 1);
		wait_for_results();
		set_regs(14'd3, 14'd40);
		press(5, 1);
		press(1, 1);
		// Entering again mid-edit with the largest codes the fields carry.
		send_word(obcs_pkg::ACT_ENTER, 1'b0, 5'd31, 6'd63);
		send_ticks(1'b0, 1);
		press(1, 1);
		press(3, 1);
		press(4, 1);
		send_word(obcs_pkg::ACT_ENTER, 1'b0, 5'd0, 6'd0);
		wait_for_results();
	endtask

	task automatic test_timeout_extremes();
		set_regs(14'd0, 14'd0);
		send_word(obcs_pkg::ACT_ENTER, 1'b0, 5'd12, 6'd30);
		send_ticks(1'b0, 2);
		wait_for_results();
		set_regs(14'd0, 14'd1);
		send_word(obcs_pkg::ACT_ENTER, 1'b1, 5'd7, 6'd45);
		send_ticks(1'b1, 1);
		send_ticks(1'b0, 2);
		wait_for_results();
		// With no press threshold every press swaps the field.
		set_regs(14'd0, 14'd30);
		send_word(obcs_pkg::ACT_ENTER, 1'b0, 5'd22, 6'd58);
		send_ticks(1'b0, 1);
		press(1, 1);
		press(1, 2);
		press(1, 1);
		press(1, 35);
		wait_for_results();
	endtask

	// No gaps on either side: a slow short press, blink refreshes and a full timeout.
	task automatic test_steady_stream();
		set_regs(obcs_pkg::CNT_MAX, 14'd300);
		src_steady = 1'b1;
		sink_steady <= 1'b1;
		send_word(obcs_pkg::ACT_ENTER, 1'b0, 5'd5, 6'd5);
		send_ticks(1'b0, 1);
		press(150, 310);
		src_steady = 1'b0;
		sink_steady <= 1'b0;
		wait_for_results();
	endtask

	task automatic test_backpressure();
		set_regs(14'd5, 14'd200);
		send_word(obcs_pkg::ACT_ENTER, 1'b0, 5'd10, 6'd20);
		fork
			begin
				sink_stall <= 1'b1;
				repeat (100) @(posedge clk);
				sink_stall <= 1'b0;
			end
			begin
				for (int i = 0; i < 10; i++)
					press($urandom_range(8, 1), $urandom_range(4, 1));
			end
		join
		wait_for_results();
		for (int i = 0; i < 5; i++)
			press($urandom_range(8, 1), $urandom_range(4, 1));
		wait_for_results();
	endtask

	task automatic run_session(input int unsigned room);
		int unsigned budget;
		int unsigned len;
		int unsigned gap;
		int unsigned threshold;
		logic [4:0]  hour;
		logic [5:0]  minute;
		threshold = m_long_press;
		hour = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 24)) : 5'($urandom_range(23));
		minute = ($urandom_range(9) == 0) ? 6'($urandom_range(63, 60)) :
			6'($urandom_range(59));
		send_word(obcs_pkg::ACT_ENTER, 1'($urandom_range(1)), hour, minute);
		send_ticks(1'b1, $urandom_range(3));
		send_ticks(1'b0, 1);
		budget = (m_timeout > 256) ? $urandom_range(600, 260) : $urandom_range(120, 10);
		if (budget > room)
			budget = room;
		while (budget > 0) begin
			if ($urandom_range(19) == 0) begin
				// Stray word, possibly a fresh entry in the middle of the edit.
				send_word(1'($urandom_range(1)), 1'($urandom_range(1)), 5'($urandom),
					6'($urandom));
				len = 1;
			end else begin
				if ($urandom_range(2) != 0)
					len = $urandom_range(8, 1);
				else if (threshold < 64)
					len = threshold + $urandom_range(1);
				else
					len = $urandom_range(64, 1);
				if (len == 0)
					len = 1;
				gap = $urandom_range(30, 1);
				press(len, gap);
				len = len + gap;
			end
			budget = (len >= budget) ? 0 : budget - len;
		end
	endtask

	task automatic test_random_sessions();
		logic [obcs_pkg::CNT_W-1:0] long_press;
		logic [obcs_pkg::CNT_W-1:0] timeout;
		while (n_words < TOTAL_WORDS) begin
			wait_for_results();
			case ($urandom_range(9))
				0: long_press = '0;
				1: long_press = obcs_pkg::CNT_MAX;
				2, 3, 4, 5: long_press = 14'($urandom_range(8, 1));
				default: long_press = 14'($urandom_range(60, 9));
			endcase
			case ($urandom_range(9))
				0: timeout = '0;
				1: timeout = 14'd1;
				2: timeout = obcs_pkg::CNT_MAX;
				3, 4, 5: timeout = 14'($urandom_range(64, 2));
				default: timeout = 14'($urandom_range(700, 200));
			endcase
			set_regs(long_press, timeout);
			run_session(TOTAL_WORDS - n_words);
		end
		wait_for_results();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_editing();
		test_timeout_extremes();
		test_steady_stream();
		test_backpressure();
		test_random_sessions();
		wait_for_results();
		if (expected_readouts.size() != 0)
			report_mismatch("undelivered result words", expected_readouts.size(), 0);
		$display("Checked %0d result words from %0d words sent, %0d of them working: %0d commits, %0d refreshes.",
			n_results, n_words, n_worked, n_commits, n_refreshes);
		$display("Covered wraps, long and short presses, timeout extremes and output stalls.");
		if (n_mismatch == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/obcs_pkg.sv
design/obcs_set_pass.sv
design/one_button_clock_setter_core.sv
design/obcs_checker.sv
tb/sv/tb_one_button_clock_setter_core.sv
